// ===== rtl/core/hctp_pkg.sv =====
// package for the hex colour text parser
// holds the beat structs, the parse phase enum and the character class struct
// no dependencies
package hctp_pkg;

    localparam int unsigned CharWidth  = 8;
    localparam int unsigned ByteWidth  = 8;
    localparam int unsigned NibWidth   = 4;
    localparam int unsigned AccWidth   = 24;
    localparam int unsigned CountWidth = 3;

    localparam logic [CharWidth-1:0] CharHash  = 8'h23;
    localparam logic [CharWidth-1:0] CharSpace = 8'h20;
    localparam logic [CharWidth-1:0] CharTab   = 8'h09;
    localparam logic [CharWidth-1:0] CharCr    = 8'h0D;
    localparam logic [CharWidth-1:0] CharZero  = 8'h30;
    localparam logic [CharWidth-1:0] CharNine  = 8'h39;
    localparam logic [CharWidth-1:0] CharLowA  = 8'h61;
    localparam logic [CharWidth-1:0] CharLowF  = 8'h66;
    localparam logic [CharWidth-1:0] CharUpA   = 8'h41;
    localparam logic [CharWidth-1:0] CharUpF   = 8'h46;

    localparam logic [CountWidth-1:0] CountShort = 3'd3;
    localparam logic [CountWidth-1:0] CountLong  = 3'd6;
    localparam logic [CountWidth-1:0] CountOver  = 3'd7;

    // input beat
    typedef struct packed {
        logic [CharWidth-1:0] char_code;
        logic                 is_last;
    } hctp_in_t;

    // result beat
    typedef struct packed {
        logic                 color_ok;
        logic [ByteWidth-1:0] red;
        logic [ByteWidth-1:0] green;
        logic [ByteWidth-1:0] blue;
    } hctp_out_t;

    // character class handed from the classifier to the parser
    typedef struct packed {
        logic                is_space;
        logic                is_hash;
        logic                is_hex;
        logic [NibWidth-1:0] nibble;
    } hctp_class_t;

    typedef enum logic [1:0] {
        PH_LEAD,
        PH_BODY,
        PH_TRAIL,
        PH_BAD
    } hctp_phase_t;

endpackage

// ===== rtl/core/hctp_char_class.sv =====
// character classifier for the hex colour text parser
// flags whitespace, '#' and hex digits and gives the digit value
// depends on hctp_pkg
module hctp_char_class (
    input  logic [hctp_pkg::CharWidth-1:0] char_code,
    output hctp_pkg::hctp_class_t          cls
);
    import hctp_pkg::*;

    logic [CharWidth-1:0] offset;

    // whitespace, hash and digit detection with nibble value
    always_comb begin
        cls          = '0;
        offset       = '0;
        cls.is_space = (char_code == CharSpace) || (char_code inside {[CharTab:CharCr]});
        cls.is_hash  = (char_code == CharHash);
        if (char_code inside {[CharZero:CharNine]}) begin
            offset     = char_code - CharZero;
            cls.is_hex = 1'b1;
        end else if (char_code inside {[CharLowA:CharLowF]}) begin
            offset     = char_code - CharLowA + 8'd10;
            cls.is_hex = 1'b1;
        end else if (char_code inside {[CharUpA:CharUpF]}) begin
            offset     = char_code - CharUpA + 8'd10;
            cls.is_hex = 1'b1;
        end
        cls.nibble = offset[NibWidth-1:0];
    end

endmodule

// ===== rtl/core/hctp_parser.sv =====
// parse state of the hex colour text parser: phase, digit count, nibble shift register
// steps once per character and forms the colour for the final character
// depends on hctp_pkg
module hctp_parser (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step_en,
    input  logic                  is_last,
    input  hctp_pkg::hctp_class_t cls,
    output hctp_pkg::hctp_out_t   result
);
    import hctp_pkg::*;

    hctp_phase_t           phase_reg, phase_next;
    logic [CountWidth-1:0] count_reg, count_next;
    logic [AccWidth-1:0]   acc_reg, acc_next;
    logic                  take_digit;

    // next phase, count and accumulator for this character
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        acc_next   = acc_reg;
        take_digit = 1'b0;
        case (phase_reg)
            PH_LEAD: begin
                if (cls.is_space) begin
                    phase_next = PH_LEAD;
                end else if (cls.is_hash) begin
                    phase_next = PH_BODY;
                end else if (cls.is_hex) begin
                    take_digit = 1'b1;
                end else begin
                    phase_next = PH_BAD;
                end
            end
            PH_BODY: begin
                if (cls.is_space) begin
                    phase_next = PH_TRAIL;
                end else if (cls.is_hex) begin
                    take_digit = 1'b1;
                end else begin
                    phase_next = PH_BAD;
                end
            end
            PH_TRAIL: begin
                if (!cls.is_space) begin
                    phase_next = PH_BAD;
                end
            end
            default: begin
                phase_next = PH_BAD;
            end
        endcase
        // a seventh digit marks the string bad
        if (take_digit) begin
            if (count_reg >= CountLong) begin
                count_next = CountOver;
                phase_next = PH_BAD;
            end else begin
                acc_next   = {acc_reg[AccWidth-NibWidth-1:0], cls.nibble};
                count_next = count_reg + 3'd1;
                phase_next = PH_BODY;
            end
        end
    end

    // colour from the state after this character
    always_comb begin
        result = '0;
        if (phase_next != PH_BAD && phase_next != PH_LEAD) begin
            if (count_next == CountLong) begin
                result.color_ok = 1'b1;
                result.red      = acc_next[23:16];
                result.green    = acc_next[15:8];
                result.blue     = acc_next[7:0];
            end else if (count_next == CountShort) begin
                result.color_ok = 1'b1;
                result.red      = {acc_next[11:8], acc_next[11:8]};
                result.green    = {acc_next[7:4], acc_next[7:4]};
                result.blue     = {acc_next[3:0], acc_next[3:0]};
            end
        end
    end

    // state registers, back to reset values after the final character
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_LEAD;
            count_reg <= '0;
            acc_reg   <= '0;
        end else if (step_en) begin
            if (is_last) begin
                phase_reg <= PH_LEAD;
                count_reg <= '0;
                acc_reg   <= '0;
            end else begin
                phase_reg <= phase_next;
                count_reg <= count_next;
                acc_reg   <= acc_next;
            end
        end
    end

    a_over_is_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == CountOver |-> phase_reg == PH_BAD)
        else $error("digit count overflow without bad phase");

    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        step_en && is_last |=> phase_reg == PH_LEAD && count_reg == '0 && acc_reg == '0)
        else $error("parse state not cleared after final character");

    a_lead_no_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_LEAD |-> count_reg == '0)
        else $error("digits counted in leading phase");

endmodule

// ===== rtl/core/hex_color_text_parser.sv =====
// top level of the hex colour text parser
// input register, parse step and result register with valid/ready on both sides
// depends on hctp_pkg, hctp_char_class, hctp_parser
//
//  channel | ports                     | beat
//  --------+---------------------------+-------------------------------------
//  input   | s_valid s_ready s_data    | one character, last flag
//  result  | m_valid m_ready m_data    | colour ok flag, red, green, blue
//
// one character per cycle sustained, unless a final character waits for a stalled
// result; a final character passes the input register, then the result register
// characters that are not final pass the parse step without using the result register
// a stalled result holds only a final character in the input register
// synchronous active-low reset empties both registers and clears the parse state
module hex_color_text_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  hctp_pkg::hctp_in_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output hctp_pkg::hctp_out_t  m_data
);
    import hctp_pkg::*;

    logic        in_valid_reg;
    hctp_in_t    in_data_reg;
    hctp_out_t   out_data_reg;
    logic        out_valid_reg;
    logic        out_free;
    logic        step_en;
    logic        load_out;
    hctp_class_t cls;
    hctp_out_t   result;

    // handshake and advance
    assign out_free = !out_valid_reg || m_ready;
    assign step_en  = in_valid_reg && (!in_data_reg.is_last || out_free);
    assign load_out = step_en && in_data_reg.is_last;
    assign s_ready  = !in_valid_reg || step_en;
    assign m_valid  = out_valid_reg;
    assign m_data   = out_data_reg;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    hctp_char_class u_class (
        .char_code (in_data_reg.char_code),
        .cls       (cls)
    );

    hctp_parser u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .is_last (in_data_reg.is_last),
        .cls     (cls),
        .result  (result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_data_reg <= result;
        end
    end

    a_invalid_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.color_ok |-> m_data.red == '0 && m_data.green == '0
            && m_data.blue == '0)
        else $error("invalid colour with nonzero bytes");

    a_empty_takes: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("empty input register refuses a beat");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |-> !load_out)
        else $error("result register overwritten while stalled");

endmodule
